[hw/rtl/stereo_gated_envelope_filter_macros.svh]
// Assertion helpers for the top-level RTL file.
`ifndef STEREO_GATED_ENVELOPE_FILTER_MACROS_SVH
`define STEREO_GATED_ENVELOPE_FILTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SGEF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgef assertion failed");
// next-cycle implication
`define SGEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgef assertion failed");
`else
`define SGEF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define SGEF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/sgef_pkg.sv]
`timescale 1ns / 1ps
package sgef_pkg;
    localparam int DEF_SAMPLE_BITS    = 24;
    localparam int DEF_COEF_FRAC_BITS = 22;
    localparam int REL_FRAC           = 23;
    localparam int CFG_IDX_BITS       = 3;
    localparam int CFG_DATA_BITS      = 24;
    localparam int THR_BITS           = 23;
    localparam int FACT_BITS          = 24;

    localparam logic [FACT_BITS-1:0] FACT_ONE       = 24'd8388608;
    localparam logic [FACT_BITS-1:0] ATTACK_RST     = 24'd12583;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD      = 3'd0,
        CFG_TREBLE_RELEASE = 3'd1,
        CFG_BASS_RELEASE   = 3'd2,
        CFG_ATTACK_STEP    = 3'd3,
        CFG_WET_MIX        = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_ENV_START, S_ENV_WAIT, S_GATE, S_LP_MUL, S_LP,
        S_HP_MUL, S_HP, S_MIX_MUL, S_MIX, S_DONE
    } t_top_st;

    typedef enum logic [2:0] {
        C_IDLE, C_ATK_MUL, C_ATK, C_TRE_MUL, C_TRE, C_BAS_MUL, C_BAS
    } t_coef_st;

    typedef enum logic [2:0] {
        OP_NONE, OP_GATE, OP_LP_MUL, OP_LP, OP_HP_MUL, OP_HP, OP_MIX_MUL, OP_MIX
    } t_lane_op;

    typedef struct packed {
        t_lane_op op;
        logic     bank;
    } t_lane_ctl;

    typedef struct packed {
        logic done;
        logic gate;
    } t_coef_stat;
endpackage

[hw/rtl/sgef_in_if.sv]
`timescale 1ns / 1ps
interface sgef_in_if #(
    parameter int SAMPLE_BITS = sgef_pkg::DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

[hw/rtl/sgef_out_if.sv]
`timescale 1ns / 1ps
interface sgef_out_if #(
    parameter int SAMPLE_BITS = sgef_pkg::DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

[hw/rtl/sgef_coef.sv]
`timescale 1ns / 1ps
// Envelope unit: attack step, gate decision and treble/bass relax on one
// shared multiplier.
module sgef_coef #(
    parameter int SAMPLE_BITS    = sgef_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = sgef_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [SAMPLE_BITS-1:0]              i_mag,
    input  logic [sgef_pkg::THR_BITS-1:0]       i_threshold,
    input  logic [sgef_pkg::FACT_BITS-1:0]      i_attack_step,
    input  logic [sgef_pkg::FACT_BITS-1:0]      i_treble_release,
    input  logic [sgef_pkg::FACT_BITS-1:0]      i_bass_release,
    output logic [COEF_FRAC_BITS+1:0]           o_treble,
    output logic [COEF_FRAC_BITS+1:0]           o_bass,
    output sgef_pkg::t_coef_stat                o_stat
);
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int DW = COEF_FRAC_BITS + 3;
    localparam int MA = (SAMPLE_BITS + 1 > DW) ? SAMPLE_BITS + 1 : DW;
    localparam int MB = sgef_pkg::FACT_BITS + 1;
    localparam int PW = MA + MB;
    localparam int GW = (SAMPLE_BITS > sgef_pkg::THR_BITS) ? SAMPLE_BITS : sgef_pkg::THR_BITS;
    localparam int SW = ((CW > MB) ? CW : MB) + 1;
    localparam logic [CW-1:0] C_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};
    localparam logic [CW-1:0] C_TWO = {2'b10, {COEF_FRAC_BITS{1'b0}}};

    sgef_pkg::t_coef_st r_st, n_st;
    logic [CW-1:0]        r_treble, n_treble;
    logic [CW-1:0]        r_bass, n_bass;
    logic signed [PW-1:0] r_prod;

    logic                 w_gate;
    logic signed [DW-1:0] w_diff;
    logic signed [MA-1:0] w_a;
    logic signed [MB-1:0] w_b;
    logic [sgef_pkg::FACT_BITS-1:0] w_atk;
    logic [SW-1:0]        w_tsum;
    logic signed [SW:0]   w_bsub;
    logic signed [PW-1:0] w_rel;
    logic [CW-1:0]        w_bnew;

    assign w_gate = GW'(i_mag) > GW'(i_threshold);
    assign w_diff = signed'(DW'(r_treble)) - signed'(DW'(r_bass));
    assign w_atk  = i_attack_step - sgef_pkg::FACT_BITS'(r_prod >>> SAMPLE_BITS);
    assign w_tsum = SW'(r_treble) + SW'(w_atk);
    assign w_bsub = signed'((SW + 1)'(r_bass)) - signed'((SW + 1)'({w_atk, 1'b0}));
    assign w_rel  = r_prod >>> sgef_pkg::REL_FRAC;
    assign w_bnew = r_treble + CW'(w_rel);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            sgef_pkg::C_IDLE:    if (i_start) n_st = sgef_pkg::C_ATK_MUL;
            sgef_pkg::C_ATK_MUL: n_st = sgef_pkg::C_ATK;
            sgef_pkg::C_ATK:     n_st = w_gate ? sgef_pkg::C_IDLE : sgef_pkg::C_TRE_MUL;
            sgef_pkg::C_TRE_MUL: n_st = sgef_pkg::C_TRE;
            sgef_pkg::C_TRE:     n_st = sgef_pkg::C_BAS_MUL;
            sgef_pkg::C_BAS_MUL: n_st = sgef_pkg::C_BAS;
            sgef_pkg::C_BAS:     n_st = sgef_pkg::C_IDLE;
            default:             n_st = sgef_pkg::C_IDLE;
        endcase
    end

    // operands and coefficient updates
    always_comb begin
        w_a      = '0;
        w_b      = '0;
        n_treble = r_treble;
        n_bass   = r_bass;
        o_stat   = '0;
        case (r_st)
            sgef_pkg::C_ATK_MUL: begin
                w_a = MA'({1'b0, i_mag});
                w_b = MB'({1'b0, i_attack_step});
            end
            sgef_pkg::C_ATK: begin
                if (w_gate) begin
                    o_stat.done = 1'b1;
                    o_stat.gate = 1'b1;
                    n_treble = (w_tsum > SW'(C_TWO)) ? C_TWO : CW'(w_tsum);
                    n_bass   = w_bsub[SW] ? '0 : CW'(w_bsub);
                end
            end
            sgef_pkg::C_TRE_MUL: begin
                w_a = MA'(w_diff);
                w_b = MB'({1'b0, i_treble_release});
            end
            sgef_pkg::C_TRE: n_treble = r_bass + CW'(w_rel);
            sgef_pkg::C_BAS_MUL: begin
                w_a = MA'(-w_diff);
                w_b = MB'({1'b0, i_bass_release});
            end
            sgef_pkg::C_BAS: begin
                o_stat.done = 1'b1;
                n_bass = (w_bnew > C_ONE) ? C_ONE : w_bnew;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= sgef_pkg::C_IDLE;
            r_treble <= C_ONE;
            r_bass   <= '0;
        end else begin
            r_st     <= n_st;
            r_treble <= n_treble;
            r_bass   <= n_bass;
        end
        r_prod <= w_a * w_b;
    end

    assign o_treble = r_treble;
    assign o_bass   = r_bass;
endmodule

[hw/rtl/sgef_lane.sv]
`timescale 1ns / 1ps
// One channel: lowpass/highpass for banks A and B, dry/wet mix, one multiplier.
module sgef_lane #(
    parameter int SAMPLE_BITS    = sgef_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = sgef_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sgef_pkg::t_lane_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]  i_x,
    input  logic [COEF_FRAC_BITS+1:0]      i_treble,
    input  logic [COEF_FRAC_BITS+1:0]      i_bass,
    input  logic [sgef_pkg::FACT_BITS-1:0] i_wet,
    output logic signed [SAMPLE_BITS-1:0]  o_y
);
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int LW = SAMPLE_BITS + 2;
    localparam int AW = SAMPLE_BITS + 4;
    localparam int BW = (COEF_FRAC_BITS + 3 > sgef_pkg::FACT_BITS + 1) ?
                        COEF_FRAC_BITS + 3 : sgef_pkg::FACT_BITS + 1;
    localparam int PW = AW + BW;
    localparam logic [CW-1:0] C_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};
    localparam logic signed [AW-1:0] S_MAX = AW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [AW-1:0] S_MIN = ~S_MAX;

    logic signed [LW-1:0] r_lp [2];
    logic signed [LW-1:0] r_hp [2];
    logic signed [PW-1:0] r_prod;
    logic signed [SAMPLE_BITS-1:0] r_y;

    logic                 w_idx;   // 0: bank A, 1: bank B
    logic signed [LW-1:0] w_xe, w_lp, w_hp;
    logic signed [LW:0]   w_proc;
    logic signed [AW-1:0] w_a, w_y;
    logic signed [BW-1:0] w_b;

    assign w_idx  = ~i_ctl.bank;
    assign w_xe   = LW'(i_x);
    assign w_lp   = r_lp[w_idx];
    assign w_hp   = r_hp[w_idx];
    assign w_proc = (i_treble > i_bass) ? ((LW + 1)'(w_lp) - (LW + 1)'(w_hp)) : '0;
    assign w_y    = AW'(i_x) + AW'(r_prod >>> sgef_pkg::REL_FRAC);

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (i_ctl.op)
            sgef_pkg::OP_LP_MUL: begin
                w_a = AW'(w_xe) - AW'(w_lp);
                w_b = BW'({1'b0, i_treble});
            end
            sgef_pkg::OP_HP_MUL: begin
                w_a = AW'(w_xe) - AW'(w_hp);
                w_b = BW'({1'b0, i_bass});
            end
            sgef_pkg::OP_MIX_MUL: begin
                w_a = AW'(w_proc) - AW'(i_x);
                w_b = BW'({1'b0, i_wet});
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp[0] <= '0;
            r_lp[1] <= '0;
            r_hp[0] <= '0;
            r_hp[1] <= '0;
        end else begin
            case (i_ctl.op)
                sgef_pkg::OP_GATE: begin
                    r_lp[0] <= w_xe;
                    r_lp[1] <= w_xe;
                    r_hp[0] <= '0;
                    r_hp[1] <= '0;
                end
                sgef_pkg::OP_LP:
                    r_lp[w_idx] <= (i_treble >= C_ONE) ? w_xe :
                                   w_lp + LW'(r_prod >>> COEF_FRAC_BITS);
                sgef_pkg::OP_HP:
                    r_hp[w_idx] <= (i_bass != '0) ?
                                   w_hp + LW'(r_prod >>> COEF_FRAC_BITS) : '0;
                default: ;
            endcase
        end
        r_prod <= w_a * w_b;
        if (i_ctl.op == sgef_pkg::OP_MIX) begin
            if (w_y > S_MAX)      r_y <= S_MAX[SAMPLE_BITS-1:0];
            else if (w_y < S_MIN) r_y <= S_MIN[SAMPLE_BITS-1:0];
            else                  r_y <= w_y[SAMPLE_BITS-1:0];
        end
    end

    assign o_y = r_y;
endmodule

[hw/rtl/stereo_gated_envelope_filter.sv]
`timescale 1ns / 1ps
// Stereo gated envelope filter. Each input word is one stereo pair (Q1.23);
// each output word is the processed pair, dry/wet mixed and saturated. The
// block handles one pair at a time: each pair runs through the envelope
// unit's multiplier sequence (attack, treble relax, bass relax; the relax
// multiplies are skipped when the gate fires) followed by three multiplies
// per channel lane (lowpass, highpass, mix). The next word can be taken in
// the cycle after the result is loaded, as soon as the previous pair has
// reached the output register, even if that result is still waiting
// downstream. Config writes go through i_cfg_we/i_cfg_index/i_cfg_data;
// the three factor registers clamp at 1.0 and unknown indices are dropped.
// Write config only while idle.
`include "stereo_gated_envelope_filter_macros.svh"
module stereo_gated_envelope_filter #(
    parameter int SAMPLE_BITS    = sgef_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_FRAC_BITS = sgef_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgef_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [sgef_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    sgef_in_if.sink                            i_in,
    sgef_out_if.source                         o_out
);
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam logic [CW-1:0] C_ONE = {2'b01, {COEF_FRAC_BITS{1'b0}}};
    localparam logic [CW-1:0] C_TWO = {2'b10, {COEF_FRAC_BITS{1'b0}}};

    // config registers
    logic [sgef_pkg::THR_BITS-1:0]  r_threshold;
    logic [sgef_pkg::FACT_BITS-1:0] r_treble_rel, r_bass_rel, r_attack, r_wet;
    logic [sgef_pkg::FACT_BITS-1:0] w_capped;

    // sequencer and per-word state
    sgef_pkg::t_top_st r_st, n_st;
    logic signed [SAMPLE_BITS-1:0] r_x_l, r_x_r;
    logic [SAMPLE_BITS-1:0]        r_mag;
    logic                          r_bank;   // 1 selects bank A, 0 bank B
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;

    logic [SAMPLE_BITS-1:0] w_mag_l, w_mag_r;
    logic                   w_accept, w_load, w_start;
    sgef_pkg::t_lane_ctl    w_ctl;
    sgef_pkg::t_coef_stat   w_stat;
    logic [CW-1:0]          w_treble, w_bass;
    logic signed [SAMPLE_BITS-1:0] w_y_l, w_y_r;

    assign w_capped = (i_cfg_data > sgef_pkg::FACT_ONE) ? sgef_pkg::FACT_ONE : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= '0;
            r_treble_rel <= sgef_pkg::FACT_ONE;
            r_bass_rel   <= sgef_pkg::FACT_ONE;
            r_attack     <= sgef_pkg::ATTACK_RST;
            r_wet        <= sgef_pkg::FACT_ONE;
        end else if (i_cfg_we) begin
            case (sgef_pkg::t_cfg_idx'(i_cfg_index))
                sgef_pkg::CFG_THRESHOLD:      r_threshold  <= i_cfg_data[sgef_pkg::THR_BITS-1:0];
                sgef_pkg::CFG_TREBLE_RELEASE: r_treble_rel <= w_capped;
                sgef_pkg::CFG_BASS_RELEASE:   r_bass_rel   <= w_capped;
                sgef_pkg::CFG_ATTACK_STEP:    r_attack     <= i_cfg_data;
                sgef_pkg::CFG_WET_MIX:        r_wet        <= w_capped;
                default: ;
            endcase
        end
    end

    // magnitudes; the most negative sample maps to 2^(SAMPLE_BITS-1)
    assign w_mag_l = i_in.left_sample[SAMPLE_BITS-1]  ? (~i_in.left_sample + 1'b1)
                                                      : i_in.left_sample;
    assign w_mag_r = i_in.right_sample[SAMPLE_BITS-1] ? (~i_in.right_sample + 1'b1)
                                                      : i_in.right_sample;

    assign i_in.ready = (r_st == sgef_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_load     = (r_st == sgef_pkg::S_DONE) && (!r_out_valid || o_out.ready);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            sgef_pkg::S_IDLE:      if (w_accept) n_st = sgef_pkg::S_ENV_START;
            sgef_pkg::S_ENV_START: n_st = sgef_pkg::S_ENV_WAIT;
            sgef_pkg::S_ENV_WAIT:
                if (w_stat.done) n_st = w_stat.gate ? sgef_pkg::S_GATE : sgef_pkg::S_LP_MUL;
            sgef_pkg::S_GATE:      n_st = sgef_pkg::S_LP_MUL;
            sgef_pkg::S_LP_MUL:    n_st = sgef_pkg::S_LP;
            sgef_pkg::S_LP:        n_st = sgef_pkg::S_HP_MUL;
            sgef_pkg::S_HP_MUL:    n_st = sgef_pkg::S_HP;
            sgef_pkg::S_HP:        n_st = sgef_pkg::S_MIX_MUL;
            sgef_pkg::S_MIX_MUL:   n_st = sgef_pkg::S_MIX;
            sgef_pkg::S_MIX:       n_st = sgef_pkg::S_DONE;
            sgef_pkg::S_DONE:      if (w_load) n_st = sgef_pkg::S_IDLE;
            default:               n_st = sgef_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: envelope start and lane op
    always_comb begin
        w_start   = 1'b0;
        w_ctl.op  = sgef_pkg::OP_NONE;
        w_ctl.bank = r_bank;
        case (r_st)
            sgef_pkg::S_ENV_START: w_start  = 1'b1;
            sgef_pkg::S_GATE:      w_ctl.op = sgef_pkg::OP_GATE;
            sgef_pkg::S_LP_MUL:    w_ctl.op = sgef_pkg::OP_LP_MUL;
            sgef_pkg::S_LP:        w_ctl.op = sgef_pkg::OP_LP;
            sgef_pkg::S_HP_MUL:    w_ctl.op = sgef_pkg::OP_HP_MUL;
            sgef_pkg::S_HP:        w_ctl.op = sgef_pkg::OP_HP;
            sgef_pkg::S_MIX_MUL:   w_ctl.op = sgef_pkg::OP_MIX_MUL;
            sgef_pkg::S_MIX:       w_ctl.op = sgef_pkg::OP_MIX;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= sgef_pkg::S_IDLE;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (w_load) begin
                r_bank      <= ~r_bank;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_x_l <= i_in.left_sample;
            r_x_r <= i_in.right_sample;
            r_mag <= (w_mag_l > w_mag_r) ? w_mag_l : w_mag_r;
        end
        if (w_load) begin
            r_out_l <= w_y_l;
            r_out_r <= w_y_r;
        end
    end

    // envelope unit (shared by both channels)
    sgef_coef #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_start),
        .i_mag            (r_mag),
        .i_threshold      (r_threshold),
        .i_attack_step    (r_attack),
        .i_treble_release (r_treble_rel),
        .i_bass_release   (r_bass_rel),
        .o_treble         (w_treble),
        .o_bass           (w_bass),
        .o_stat           (w_stat)
    );

    // channel lanes run in lockstep
    sgef_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_x      (r_x_l),
        .i_treble (w_treble),
        .i_bass   (w_bass),
        .i_wet    (r_wet),
        .o_y      (w_y_l)
    );

    sgef_lane #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_x      (r_x_r),
        .i_treble (w_treble),
        .i_bass   (w_bass),
        .i_wet    (r_wet),
        .o_y      (w_y_r)
    );

    // output register
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    `SGEF_ASSERT_NEXT(a_accept_starts_env, i_clk, i_rst_n, w_accept, r_st == sgef_pkg::S_ENV_START)
    `SGEF_ASSERT_NEXT(a_coef_in_range, i_clk, i_rst_n, w_stat.done, (w_bass <= C_ONE) && (w_treble <= C_TWO))
    `SGEF_ASSERT_NEXT(a_bank_toggles, i_clk, i_rst_n, w_load, (r_bank != $past(r_bank)) && r_out_valid)
endmodule
